>>> design/mrrb_pkg.sv
package mrrb_pkg;

  // Store geometry
  localparam int BUF_DEPTH   = 4096;
  localparam int PTR_W       = $clog2(BUF_DEPTH);

  // Reader slots and request limits
  localparam int NUM_READERS = 5;
  localparam int RIDX_W      = 3;
  localparam int MAX_READ    = 64;
  localparam int CNT_W       = 7;

  // Reader enable register
  localparam int EN_W = 5;
  localparam logic [EN_W-1:0] EN_RESET = EN_W'(16);

  // Sample width (Q1.15)
  localparam int SMP_W = 16;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Result queue at the output
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 2);

  // Input operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_FAIL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic signed [SMP_W-1:0]   sample_i;
    logic signed [SMP_W-1:0]   sample_q;
    logic                      chunk_last;
    logic [RIDX_W-1:0]         reader;
    logic [CNT_W-1:0]          count;
  } cmd_t;

  // True when reader slot idx exists and is registered
  function automatic logic reader_on(input logic [EN_W-1:0] en,
                                     input logic [RIDX_W-1:0] idx);
    logic on;
    on = 1'b0;
    for (int r = 0; r < NUM_READERS; r++) begin
      if (idx == RIDX_W'(r)) begin
        on = en[r];
      end
    end
    return on;
  endfunction

endpackage

>>> design/multi_reader_iq_ring_buffer_core.sv
// Ring store of 4096 signed Q1.15 I/Q pairs with one writer and five readers. A front stage
// classifies each item and hands it through a two-entry command queue to a sequencer that owns
// the sample memory (one write port, one read port). Writes run at one item per cycle while the
// sequencer is not streaming a read; a chunk-closing write rewinds any overtaken enabled reader
// in that same cycle. A read request of n samples has its availability checked first and then
// streams its samples through the memory's one read port, pausing while the result queue is
// full; a failed request yields one result with ok low. Results leave through a four-entry
// queue, so the sequencer keeps working while the consumer stalls, until the queue fills. Write
// the reader_enable register only while the block is idle.
module multi_reader_iq_ring_buffer_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_op,
  input  logic signed [mrrb_pkg::SMP_W-1:0]    in_sample_i,
  input  logic signed [mrrb_pkg::SMP_W-1:0]    in_sample_q,
  input  logic                                 in_chunk_last,
  input  logic [mrrb_pkg::RIDX_W-1:0]          in_reader_index,
  input  logic [mrrb_pkg::CNT_W-1:0]           in_read_count,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_ok,
  output logic signed [mrrb_pkg::SMP_W-1:0]    out_i,
  output logic signed [mrrb_pkg::SMP_W-1:0]    out_q,
  output logic                                 out_last,
  input  logic                                 cfg_we,
  input  logic [mrrb_pkg::EN_W-1:0]            cfg_wdata
);

  logic [mrrb_pkg::EN_W-1:0] reader_en_r;
  logic                      cmd_push;
  logic                      cmdq_full;
  logic                      cmd_vld;
  logic                      cmd_pop;
  mrrb_pkg::cmd_t            front_cmd;
  mrrb_pkg::cmd_t            back_cmd;

  // Reader enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reader_en_r <= mrrb_pkg::EN_RESET;
    end else if (cfg_we) begin
      reader_en_r <= cfg_wdata;
    end
  end

  mrrb_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_sample_i     (in_sample_i),
    .in_sample_q     (in_sample_q),
    .in_chunk_last   (in_chunk_last),
    .in_reader_index (in_reader_index),
    .in_read_count   (in_read_count),
    .reader_en       (reader_en_r),
    .cmdq_full       (cmdq_full),
    .cmd_push        (cmd_push),
    .cmd             (front_cmd)
  );

  mrrb_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (front_cmd),
    .full      (cmdq_full),
    .pop_vld   (cmd_vld),
    .pop_data  (back_cmd),
    .pop       (cmd_pop)
  );

  mrrb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .reader_en (reader_en_r),
    .cmd_vld   (cmd_vld),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_ok    (out_ok),
    .out_i     (out_i),
    .out_q     (out_q),
    .out_last  (out_last)
  );

endmodule

>>> design/mrrb_ram.sv
module mrrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/mrrb_front.sv
module mrrb_front (
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     in_op,
  input  logic signed [mrrb_pkg::SMP_W-1:0]        in_sample_i,
  input  logic signed [mrrb_pkg::SMP_W-1:0]        in_sample_q,
  input  logic                                     in_chunk_last,
  input  logic [mrrb_pkg::RIDX_W-1:0]              in_reader_index,
  input  logic [mrrb_pkg::CNT_W-1:0]               in_read_count,
  input  logic [mrrb_pkg::EN_W-1:0]                reader_en,
  input  logic                                     cmdq_full,
  output logic                                     cmd_push,
  output mrrb_pkg::cmd_t                           cmd
);

  logic drop;

  // Classify the item: write, read, a request that fails outright, or an empty read that is dropped
  always_comb begin
    cmd.kind       = mrrb_pkg::CMD_WRITE;
    cmd.sample_i   = in_sample_i;
    cmd.sample_q   = in_sample_q;
    cmd.chunk_last = in_chunk_last;
    cmd.reader     = in_reader_index;
    cmd.count      = in_read_count;
    drop           = 1'b0;
    if (in_op == mrrb_pkg::OP_READ) begin
      if (!mrrb_pkg::reader_on(reader_en, in_reader_index)) begin
        cmd.kind = mrrb_pkg::CMD_FAIL;
      end else if (in_read_count == '0) begin
        // empty request: succeeds with nothing to deliver
        drop = 1'b1;
      end else if (int'(in_read_count) > mrrb_pkg::MAX_READ ||
                   int'(in_read_count) >= mrrb_pkg::BUF_DEPTH) begin
        cmd.kind = mrrb_pkg::CMD_FAIL;
      end else begin
        cmd.kind = mrrb_pkg::CMD_READ;
      end
    end
  end

  assign in_ready = !cmdq_full;
  assign cmd_push = in_valid && in_ready && !drop;

endmodule

>>> design/mrrb_cmdq.sv
module mrrb_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mrrb_pkg::cmd_t push_data,
  output logic           full,
  output logic           pop_vld,
  output mrrb_pkg::cmd_t pop_data,
  input  logic           pop
);

  mrrb_pkg::cmd_t                    mem_r [mrrb_pkg::CMDQ_DEPTH];
  logic [mrrb_pkg::CMDQ_PTR_W-1:0]   wr_ptr_r;
  logic [mrrb_pkg::CMDQ_PTR_W-1:0]   rd_ptr_r;
  logic [mrrb_pkg::CMDQ_CNT_W-1:0]   cnt_r;
  logic                              do_push;
  logic                              do_pop;

  assign full     = (cnt_r == mrrb_pkg::CMDQ_CNT_W'(mrrb_pkg::CMDQ_DEPTH));
  assign pop_vld  = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && pop_vld;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == mrrb_pkg::CMDQ_PTR_W'(mrrb_pkg::CMDQ_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == mrrb_pkg::CMDQ_PTR_W'(mrrb_pkg::CMDQ_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> design/mrrb_back.sv
module mrrb_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [mrrb_pkg::EN_W-1:0]            reader_en,
  input  logic                                 cmd_vld,
  input  mrrb_pkg::cmd_t                       cmd,
  output logic                                 cmd_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_ok,
  output logic signed [mrrb_pkg::SMP_W-1:0]    out_i,
  output logic signed [mrrb_pkg::SMP_W-1:0]    out_q,
  output logic                                 out_last
);

  localparam int PW = mrrb_pkg::PTR_W;
  localparam int CW = mrrb_pkg::CNT_W;

  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } state_t;

  typedef struct packed {
    logic                             ok;
    logic signed [mrrb_pkg::SMP_W-1:0] i;
    logic signed [mrrb_pkg::SMP_W-1:0] q;
    logic                             last;
  } res_t;

  state_t                          state_r;
  logic [PW-1:0]                   wp_r;
  logic [PW-1:0]                   cs_r;
  logic [PW-1:0]                   clen_r;
  logic [PW-1:0]                   pos_r [mrrb_pkg::NUM_READERS];
  logic [PW-1:0]                   rd_addr_r;
  logic [CW-1:0]                   rd_left_r;
  logic                            pend_vld_r;
  logic                            pend_fail_r;
  logic                            pend_last_r;
  res_t                            oq_mem_r [mrrb_pkg::OQ_DEPTH];
  logic [mrrb_pkg::OQ_PTR_W-1:0]   oq_wp_r;
  logic [mrrb_pkg::OQ_PTR_W-1:0]   oq_rp_r;
  logic [mrrb_pkg::OQ_CNT_W-1:0]   oq_cnt_r;

  logic                            space;
  logic [PW-1:0]                   sel_pos;
  logic [PW:0]                     diff;
  logic [PW-1:0]                   avail;
  logic                            avail_ok;
  logic [PW:0]                     pos_sum;
  logic [PW-1:0]                   new_pos;
  logic [PW-1:0]                   wp_inc;
  logic [PW-1:0]                   rd_addr_inc;
  logic                            chunk_end;
  logic [mrrb_pkg::NUM_READERS-1:0] hit;
  logic                            ram_we;
  logic                            ram_re;
  logic [2*mrrb_pkg::SMP_W-1:0]    ram_rdata;
  logic                            issue_fail;
  logic                            start_read;
  logic                            oq_push;
  logic                            oq_pop;
  res_t                            push_res;
  res_t                            head_res;

  // Sample store
  mrrb_ram #(
    .WIDTH (2 * mrrb_pkg::SMP_W),
    .DEPTH (mrrb_pkg::BUF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata ({cmd.sample_i, cmd.sample_q}),
    .re    (ram_re),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // Room in the result queue, counting the item still in flight
  assign space = (oq_cnt_r + mrrb_pkg::OQ_CNT_W'(pend_vld_r)) <
                 mrrb_pkg::OQ_CNT_W'(mrrb_pkg::OQ_DEPTH);

  // Position of the requested reader
  always_comb begin
    sel_pos = '0;
    for (int r = 0; r < mrrb_pkg::NUM_READERS; r++) begin
      if (cmd.reader == mrrb_pkg::RIDX_W'(r)) begin
        sel_pos = pos_r[r];
      end
    end
  end

  // Samples visible to the reader: chunk start minus position, circular
  always_comb begin
    diff = {1'b0, cs_r} - {1'b0, sel_pos};
    if (diff[PW]) begin
      diff = diff + (PW+1)'(mrrb_pkg::BUF_DEPTH);
    end
    avail    = diff[PW-1:0];
    avail_ok = int'(avail) >= int'(cmd.count);
    pos_sum  = {1'b0, sel_pos} + (PW+1)'(cmd.count);
    if (int'(pos_sum) >= mrrb_pkg::BUF_DEPTH) begin
      pos_sum = pos_sum - (PW+1)'(mrrb_pkg::BUF_DEPTH);
    end
    new_pos = pos_sum[PW-1:0];
  end

  // Pointer steps with wrap
  assign wp_inc      = (wp_r == PW'(mrrb_pkg::BUF_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rd_addr_inc = (rd_addr_r == PW'(mrrb_pkg::BUF_DEPTH - 1)) ?
                       '0 : rd_addr_r + 1'b1;
  assign chunk_end   = cmd.chunk_last || (clen_r >= PW'(mrrb_pkg::BUF_DEPTH - 2));

  // Enabled readers caught in the span just overwritten
  always_comb begin
    for (int r = 0; r < mrrb_pkg::NUM_READERS; r++) begin
      hit[r] = reader_en[r] &&
               (((cs_r < wp_inc) && (pos_r[r] >= cs_r) && (pos_r[r] < wp_inc)) ||
                ((cs_r > wp_inc) && ((pos_r[r] < wp_inc) || (pos_r[r] >= cs_r))));
    end
  end

  // Command dispatch
  always_comb begin
    cmd_pop    = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    issue_fail = 1'b0;
    start_read = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_vld) begin
          case (cmd.kind)
            mrrb_pkg::CMD_WRITE: begin
              ram_we  = 1'b1;
              cmd_pop = 1'b1;
            end
            mrrb_pkg::CMD_FAIL: begin
              if (space) begin
                cmd_pop    = 1'b1;
                issue_fail = 1'b1;
              end
            end
            mrrb_pkg::CMD_READ: begin
              if (space) begin
                cmd_pop    = 1'b1;
                start_read = avail_ok;
                issue_fail = !avail_ok;
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      ST_STREAM: begin
        ram_re = space;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, store pointers, reader positions and result queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      cs_r        <= '0;
      clen_r      <= '0;
      rd_addr_r   <= '0;
      rd_left_r   <= '0;
      pend_vld_r  <= 1'b0;
      pend_fail_r <= 1'b0;
      pend_last_r <= 1'b0;
      oq_wp_r     <= '0;
      oq_rp_r     <= '0;
      oq_cnt_r    <= '0;
      for (int r = 0; r < mrrb_pkg::NUM_READERS; r++) begin
        pos_r[r] <= '0;
      end
    end else begin
      pend_vld_r  <= ram_re || issue_fail;
      pend_fail_r <= issue_fail;
      pend_last_r <= issue_fail || (ram_re && (rd_left_r == CW'(1)));

      case (state_r)
        ST_IDLE: begin
          if (ram_we) begin
            wp_r <= wp_inc;
            if (chunk_end) begin
              cs_r   <= wp_inc;
              clen_r <= '0;
              for (int r = 0; r < mrrb_pkg::NUM_READERS; r++) begin
                if (hit[r]) begin
                  pos_r[r] <= cs_r;
                end
              end
            end else begin
              clen_r <= clen_r + 1'b1;
            end
          end
          if (start_read) begin
            rd_addr_r <= sel_pos;
            rd_left_r <= cmd.count;
            state_r   <= ST_STREAM;
            for (int r = 0; r < mrrb_pkg::NUM_READERS; r++) begin
              if (cmd.reader == mrrb_pkg::RIDX_W'(r)) begin
                pos_r[r] <= new_pos;
              end
            end
          end
        end
        ST_STREAM: begin
          if (ram_re) begin
            rd_addr_r <= rd_addr_inc;
            rd_left_r <= rd_left_r - 1'b1;
            if (rd_left_r == CW'(1)) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (oq_push) begin
        oq_wp_r <= (oq_wp_r == mrrb_pkg::OQ_PTR_W'(mrrb_pkg::OQ_DEPTH - 1)) ?
                   '0 : oq_wp_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rp_r <= (oq_rp_r == mrrb_pkg::OQ_PTR_W'(mrrb_pkg::OQ_DEPTH - 1)) ?
                   '0 : oq_rp_r + 1'b1;
      end
      if (oq_push && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + 1'b1;
      end else if (oq_pop && !oq_push) begin
        oq_cnt_r <= oq_cnt_r - 1'b1;
      end
    end
  end

  // Result formed from store data or a failure marker
  always_comb begin
    if (pend_fail_r) begin
      push_res.ok   = 1'b0;
      push_res.i    = '0;
      push_res.q    = '0;
      push_res.last = 1'b1;
    end else begin
      push_res.ok   = 1'b1;
      push_res.i    = ram_rdata[2*mrrb_pkg::SMP_W-1:mrrb_pkg::SMP_W];
      push_res.q    = ram_rdata[mrrb_pkg::SMP_W-1:0];
      push_res.last = pend_last_r;
    end
  end

  assign oq_push = pend_vld_r;
  assign oq_pop  = out_valid && out_ready;

  // Result queue storage
  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_mem_r[oq_wp_r] <= push_res;
    end
  end

  assign head_res  = oq_mem_r[oq_rp_r];
  assign out_valid = (oq_cnt_r != '0);
  assign out_ok    = head_res.ok;
  assign out_i     = head_res.i;
  assign out_q     = head_res.q;
  assign out_last  = head_res.last;

  // The queue never overfills
  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= mrrb_pkg::OQ_CNT_W'(mrrb_pkg::OQ_DEPTH))
    else $error("result queue overfilled");

  // A result in flight always finds a free slot
  a_pend_room: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (oq_cnt_r < mrrb_pkg::OQ_CNT_W'(mrrb_pkg::OQ_DEPTH)))
    else $error("result arrived with queue full");

  // The final store read of a request is marked last and ends the stream
  a_stream_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STREAM && ram_re && rd_left_r == CW'(1)) |=>
      (state_r == ST_IDLE && pend_last_r && !pend_fail_r))
    else $error("stream did not end on last sample");

  // A stream always has samples left to fetch
  a_stream_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STREAM) |-> (rd_left_r != '0))
    else $error("stream with zero samples left");

  // Chunks are forced closed before reaching the store size
  a_chunk_len: assert property (@(posedge clk) disable iff (!rst_n)
    clen_r < PW'(mrrb_pkg::BUF_DEPTH - 1))
    else $error("chunk length overran");

endmodule

>>> tb/multi_reader_iq_ring_buffer_core_test.sv
`timescale 1ns / 1ps

module multi_reader_iq_ring_buffer_core_test;
  import mrrb_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 20;

  // One input item as seen on the in_ channel
  typedef struct {
    logic                    op;
    logic signed [SMP_W-1:0] sample_i;
    logic signed [SMP_W-1:0] sample_q;
    logic                    chunk_last;
    logic [RIDX_W-1:0]       reader;
    logic [CNT_W-1:0]        count;
  } ring_item_t;

  // One result item as seen on the out_ channel
  typedef struct {
    logic                    ok;
    logic signed [SMP_W-1:0] i_val;
    logic signed [SMP_W-1:0] q_val;
    logic                    last;
  } iq_result_t;

  // Shadow of the ring: store, pointers, reader positions, enable mask
  class ring_scoreboard;
    bit [2*SMP_W-1:0] store [BUF_DEPTH];
    bit [PTR_W-1:0]   wr_ptr;
    bit [PTR_W-1:0]   chunk_start;
    int unsigned      chunk_len;
    bit [PTR_W-1:0]   position [NUM_READERS];
    bit [EN_W-1:0]    enable;
    iq_result_t       due_samples[$];
    int               mismatches;

    function new();
      wr_ptr      = '0;
      chunk_start = '0;
      chunk_len   = 0;
      enable      = EN_RESET;
      mismatches  = 0;
      foreach (position[r]) position[r] = '0;
    endfunction

    function void set_enable(input logic [EN_W-1:0] mask);
      enable = mask;
    endfunction

    function bit reader_live(input int r);
      if (r >= NUM_READERS) return 1'b0;
      return enable[r];
    endfunction

    // Samples of closed chunks still ahead of reader r
    function int unsigned data_ready(input int r);
      bit [PTR_W-1:0] span;
      span = chunk_start - position[r];
      return 32'(span);
    endfunction

    function void push_fail();
      iq_result_t res;
      res.ok    = 1'b0;
      res.i_val = '0;
      res.q_val = '0;
      res.last  = 1'b1;
      due_samples.push_back(res);
    endfunction

    // Update the shadow for an accepted item and queue what it should produce
    function void apply_item(input ring_item_t it);
      int            r;
      int unsigned   n;
      bit [PTR_W-1:0] from;
      bit [PTR_W-1:0] to;
      bit            hit;
      bit [2*SMP_W-1:0] word;
      iq_result_t    res;
      if (it.op == OP_WRITE) begin
        store[wr_ptr] = {it.sample_i, it.sample_q};
        wr_ptr = wr_ptr + 1'b1;
        chunk_len++;
        if (it.chunk_last || chunk_len >= BUF_DEPTH - 1) begin
          // chunk closes: rewind live readers caught inside the overwritten span
          from = chunk_start;
          to   = wr_ptr;
          for (int k = 0; k < NUM_READERS; k++) begin
            hit = (from < to && position[k] >= from && position[k] < to) ||
                  (from > to && (position[k] < to || position[k] >= from));
            if (reader_live(k) && hit) position[k] = from;
          end
          chunk_start = to;
          chunk_len   = 0;
        end
        return;
      end
      r = int'(it.reader);
      n = int'(it.count);
      if (!reader_live(r)) begin
        push_fail();
        return;
      end
      if (n == 0) return;
      if (n > MAX_READ || data_ready(r) < n) begin
        push_fail();
        return;
      end
      for (int k = 0; k < n; k++) begin
        word      = store[PTR_W'(position[r] + k)];
        res.ok    = 1'b1;
        res.i_val = word[2*SMP_W-1:SMP_W];
        res.q_val = word[SMP_W-1:0];
        res.last  = (k == n - 1);
        due_samples.push_back(res);
      end
      position[r] = PTR_W'(position[r] + n);
    endfunction

    function void check_sample(input iq_result_t got);
      iq_result_t want;
      if (due_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: ok=%0d i=%0d q=%0d last=%0d",
                   got.ok, got.i_val, got.q_val, got.last);
        return;
      end
      want = due_samples.pop_front();
      if (got.ok !== want.ok || got.i_val !== want.i_val ||
          got.q_val !== want.q_val || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("mismatch: expected ok=%0d i=%0d q=%0d last=%0d, ",
                 want.ok, want.i_val, want.q_val, want.last);
          $display("got ok=%0d i=%0d q=%0d last=%0d",
                   got.ok, got.i_val, got.q_val, got.last);
        end
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_op;
  logic signed [SMP_W-1:0] in_sample_i;
  logic signed [SMP_W-1:0] in_sample_q;
  logic                    in_chunk_last;
  logic [RIDX_W-1:0]       in_reader_index;
  logic [CNT_W-1:0]        in_read_count;
  logic                    out_valid;
  logic                    out_ready;
  logic                    out_ok;
  logic signed [SMP_W-1:0] out_i;
  logic signed [SMP_W-1:0] out_q;
  logic                    out_last;
  logic                    cfg_we;
  logic [EN_W-1:0]         cfg_wdata;

  ring_scoreboard board = new();
  int tx_gap_max   = 15;
  int rx_stall_max = 15;
  int quiet_cycles = 0;

  multi_reader_iq_ring_buffer_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_sample_i     (in_sample_i),
    .in_sample_q     (in_sample_q),
    .in_chunk_last   (in_chunk_last),
    .in_reader_index (in_reader_index),
    .in_read_count   (in_read_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok          (out_ok),
    .out_i           (out_i),
    .out_q           (out_q),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result sink: random stall after each accepted item
  always @(posedge clk) begin : sink
    int stall_left;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (out_ready && out_valid) begin
      stall_left = $urandom_range(0, rx_stall_max);
      out_ready <= (stall_left == 0);
    end else if (!out_ready) begin
      if (stall_left > 0) stall_left--;
      out_ready <= (stall_left == 0);
    end
  end

  // Result check and watchdog
  always @(posedge clk) begin : watch
    iq_result_t seen;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen.ok    = out_ok;
        seen.i_val = out_i;
        seen.q_val = out_q;
        seen.last  = out_last;
        board.check_sample(seen);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL multi_reader_iq_ring_buffer_core");
        $finish;
      end
    end
  end

  function automatic ring_item_t make_write(input logic [SMP_W-1:0] si,
                                            input logic [SMP_W-1:0] sq,
                                            input logic last);
    ring_item_t it;
    it.op         = OP_WRITE;
    it.sample_i   = si;
    it.sample_q   = sq;
    it.chunk_last = last;
    it.reader     = RIDX_W'($urandom);
    it.count      = CNT_W'($urandom);
    return it;
  endfunction

  function automatic ring_item_t make_read(input int r, input int n);
    ring_item_t it;
    it.op         = OP_READ;
    it.sample_i   = SMP_W'($urandom);
    it.sample_q   = SMP_W'($urandom);
    it.chunk_last = 1'($urandom);
    it.reader     = RIDX_W'(r);
    it.count      = CNT_W'(n);
    return it;
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send(input ring_item_t it);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= it.op;
    in_sample_i     <= it.sample_i;
    in_sample_q     <= it.sample_q;
    in_chunk_last   <= it.chunk_last;
    in_reader_index <= it.reader;
    in_read_count   <= it.count;
    do @(posedge clk); while (!in_ready);
    board.apply_item(it);
  endtask

  // Stop sending until every queued result is out, then let writes settle
  task automatic drain();
    in_valid <= 1'b0;
    while (board.due_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_enable(input logic [EN_W-1:0] mask);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_enable(mask);
  endtask

  // Chunks of writes mixed with reads mostly sized to what the reader can take, plus random reads
  task automatic random_traffic(input int n_items);
    int sent;
    int roll;
    int len;
    int r;
    int room;
    int n;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 59) == 0) drain();
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
          send(make_write(SMP_W'($urandom), SMP_W'($urandom),
                          (k == len - 1) ? ($urandom_range(0, 7) != 0)
                                         : ($urandom_range(0, 19) == 0)));
        sent += len;
      end else if (roll < 88) begin
        r = $urandom_range(0, NUM_READERS - 1);
        for (int t = 0; t < 8 && !board.reader_live(r); t++)
          r = $urandom_range(0, NUM_READERS - 1);
        room = board.data_ready(r);
        if (room > MAX_READ) room = MAX_READ;
        if (room == 0) n = $urandom_range(1, 8);
        else if ($urandom_range(0, 4) == 0) n = room;
        else n = $urandom_range(1, room);
        send(make_read(r, n));
        sent++;
      end else begin
        n = $urandom_range(0, (1 << CNT_W) - 1);
        send(make_read($urandom_range(0, (1 << RIDX_W) - 1), n));
        if (n != 0) sent++;
      end
    end
  endtask

  initial begin : stimulus
    int len;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_op           <= OP_WRITE;
    in_sample_i     <= '0;
    in_sample_q     <= '0;
    in_chunk_last   <= 1'b0;
    in_reader_index <= '0;
    in_read_count   <= '0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset mask leaves only the top reader registered
    send(make_read(0, 1));                         // reader not registered
    send(make_read(4, 1));                         // nothing visible yet
    send(make_read(4, 0));                         // zero count, silent
    send(make_write(16'h7FFF, 16'h8000, 1'b0));
    send(make_write(16'h8000, 16'h7FFF, 1'b0));
    send(make_write(16'hFFFF, 16'h0000, 1'b0));
    send(make_write(16'h0000, 16'hFFFF, 1'b1));    // chunk becomes visible
    send(make_read(4, 2));
    send(make_read(4, 3));                         // short of data
    send(make_read(4, 2));
    send(make_write(16'h1234, 16'hEDCB, 1'b0));    // open chunk, not visible
    send(make_read(4, 1));
    send(make_read(4, MAX_READ + 1));              // count over the limit
    send(make_read(4, (1 << CNT_W) - 1));
    send(make_read(5, 1));                         // slots past the last reader
    send(make_read(6, 1));
    send(make_read(7, 1));
    send(make_read(7, 0));
    send(make_read(4, 0));

    // All readers on, full idling both sides
    load_enable(5'b11111);
    random_traffic(140);

    // Nothing registered, no idling
    tx_gap_max   = 0;
    rx_stall_max = 0;
    load_enable(5'b00000);
    random_traffic(40);

    // One chunk run to the forced close, wrapping the store
    tx_gap_max   = 2;
    rx_stall_max = 15;
    load_enable(5'b01101);
    len = BUF_DEPTH - 1 - int'(board.chunk_len);
    for (int k = 0; k < len; k++)
      send(make_write(SMP_W'($urandom), SMP_W'($urandom), 1'b0));
    random_traffic(20);

    // Readers left behind by the wrap come back in
    tx_gap_max = 15;
    load_enable(5'b11010);
    random_traffic(130);

    // Back-to-back input against a stalling sink
    tx_gap_max = 0;
    load_enable(5'b11111);
    random_traffic(90);

    drain();
    if (board.mismatches == 0 && board.due_samples.size() == 0) begin
      $display("PASS multi_reader_iq_ring_buffer_core");
    end else begin
      $display("FAIL multi_reader_iq_ring_buffer_core");
    end
    $finish;
  end

endmodule

>>> files.f
design/mrrb_pkg.sv
design/mrrb_ram.sv
design/mrrb_front.sv
design/mrrb_cmdq.sv
design/mrrb_back.sv
design/multi_reader_iq_ring_buffer_core.sv
tb/multi_reader_iq_ring_buffer_core_test.sv
